@@ rtl/top_n_sorted_insert_assert.svh @@
// assertion macros for the sorted insertion list
// used by top_n_sorted_insert; expects clk and rst_n in scope
`ifndef TOP_N_SORTED_INSERT_ASSERT_SVH
`define TOP_N_SORTED_INSERT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define TNSI_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("top_n_sorted_insert: same cycle check failed");

// condition holds in the cycle after the trigger
`define TNSI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("top_n_sorted_insert: next cycle check failed");

`endif

@@ rtl/tnsi_pkg.sv @@
// shared types and constants of the sorted insertion list
// no dependencies
package tnsi_pkg;

  // default sizes of the list and of its entries
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int TAG_WIDTH_DEF   = 16;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int OCC_W      = 5;
  localparam int RIDX_W     = 4;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 5;

  // register reset values
  localparam logic             ORDER_DESC_RESET = 1'b1;
  localparam logic [OCC_W-1:0] CAPACITY_RESET   = 5'd16;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORDER_DESC = 4'd0,
    REG_CAPACITY   = 4'd1
  } cfg_reg_t;

  // control handed to every cell of the chain
  typedef struct packed {
    logic ins;       // insert request accepted this cycle
    logic desc;      // descending order
    logic active;    // cell holds a live entry
    logic prev_hit;  // an earlier cell was beaten, take neighbor entry
    logic append;    // cell is the append slot for an unbeaten insert
  } cell_ctrl_t;

endpackage

@@ rtl/tnsi_in_if.sv @@
// request channel of the sorted insertion list
// depends on tnsi_pkg
interface tnsi_in_if
  import tnsi_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [KEY_WIDTH-1:0] new_key;
  logic [TAG_WIDTH-1:0] new_tag;
  logic [RIDX_W-1:0]    read_index;

  modport source (output valid, operation, new_key, new_tag, read_index, input ready);
  modport sink   (input valid, operation, new_key, new_tag, read_index, output ready);
endinterface

@@ rtl/tnsi_out_if.sv @@
// result channel of the sorted insertion list
// depends on tnsi_pkg
interface tnsi_out_if
  import tnsi_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic                 evicted;
  logic [KEY_WIDTH-1:0] evicted_key;
  logic [TAG_WIDTH-1:0] evicted_tag;
  logic [OCC_W-1:0]     occupancy;
  logic [KEY_WIDTH-1:0] read_key;
  logic [TAG_WIDTH-1:0] read_tag;
  logic                 read_valid;

  modport source (output valid, accepted, evicted, evicted_key, evicted_tag, occupancy,
                  read_key, read_tag, read_valid, input ready);
  modport sink   (input valid, accepted, evicted, evicted_key, evicted_tag, occupancy,
                  read_key, read_tag, read_valid, output ready);
endinterface

@@ rtl/tnsi_cfg_if.sv @@
// configuration write channel of the sorted insertion list
// depends on tnsi_pkg
interface tnsi_cfg_if
  import tnsi_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/top_n_sorted_insert.sv @@
// top level of the sorted insertion list: chain of cells, count, result register
// depends on tnsi_pkg, tnsi_in_if, tnsi_out_if, tnsi_cfg_if, tnsi_cell and the assert header
//
// Usage: requests arrive on in_ch (insert, clear, read). Each accepted request
// gives exactly one result on out_ch, registered, in the cycle after acceptance.
// An insert is compared against every held entry at once in the cell chain;
// the first beaten cell takes the new entry and all cells after it take their
// upper neighbor's entry in the same cycle, so one request is taken per cycle while out_ch takes results.
// The throughput of one request per cycle is set by the combinational compare
// and the shift of all cells together, plus the single output register.
// cfg_ch is always ready; the user writes order and capacity between requests, unchecked.
// Reset empties the list (count to zero), selects descending order and sets
// capacity to 16. Entry storage is not cleared; it is only read below the count.
// When out_ch stalls, the finished result waits in the output register and
// in_ch takes one more request only once that result has been taken or is
// being taken in the same cycle.
`include "top_n_sorted_insert_assert.svh"
module top_n_sorted_insert
  import tnsi_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  tnsi_in_if.sink    in_ch,
  tnsi_out_if.source out_ch,
  tnsi_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic             desc_r;
  logic [OCC_W-1:0] cap_r;
  logic [OCC_W-1:0] cap_eff;

  // list state
  logic [OCC_W-1:0] count_r;
  logic [OCC_W-1:0] count_nxt;

  // chain wiring
  logic                 hit   [MAX_ENTRIES];
  logic                 any_hit [MAX_ENTRIES+1];
  logic [KEY_WIDTH-1:0] cell_key [MAX_ENTRIES];
  logic [TAG_WIDTH-1:0] cell_tag [MAX_ENTRIES];
  cell_ctrl_t           cell_ctrl [MAX_ENTRIES];

  // request decode
  logic in_fire;
  logic op_ins;
  logic op_clr;
  logic op_rd;
  logic full;
  logic beaten;
  logic append_ok;

  // result values for the current request
  logic                 res_accepted;
  logic                 res_evicted;
  logic [KEY_WIDTH-1:0] res_ev_key;
  logic [TAG_WIDTH-1:0] res_ev_tag;
  logic [KEY_WIDTH-1:0] res_rd_key;
  logic [TAG_WIDTH-1:0] res_rd_tag;
  logic                 res_rd_valid;

  // output register
  logic                 out_valid_r;
  logic                 accepted_r;
  logic                 evicted_r;
  logic [KEY_WIDTH-1:0] ev_key_r;
  logic [TAG_WIDTH-1:0] ev_tag_r;
  logic [OCC_W-1:0]     occ_r;
  logic [KEY_WIDTH-1:0] rd_key_r;
  logic [TAG_WIDTH-1:0] rd_tag_r;
  logic                 rd_valid_r;

  // configuration writes, always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= ORDER_DESC_RESET;
      cap_r  <= CAPACITY_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ORDER_DESC: desc_r <= cfg_ch.data[0];
        REG_CAPACITY:   cap_r  <= cfg_ch.data[OCC_W-1:0];
        default: ;
      endcase
    end
  end

  // capacity clamped to one and to the list size
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = OCC_W'(1);
    end else if (int'(cap_r) > MAX_ENTRIES) begin
      cap_eff = OCC_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_r;
    end
  end

  // request handshake and decode
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign op_ins      = (in_ch.operation == OP_INSERT);
  assign op_clr      = (in_ch.operation == OP_CLEAR);
  assign op_rd       = (in_ch.operation == OP_READ);

  // running or of beaten cells along the chain
  assign any_hit[0] = 1'b0;
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_any
    assign any_hit[i+1] = any_hit[i] || hit[i];
  end

  assign beaten    = any_hit[MAX_ENTRIES];
  assign full      = (count_r >= cap_eff);
  assign append_ok = !beaten && !full;

  // cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] nbr_key;
    logic [TAG_WIDTH-1:0] nbr_tag;

    if (i == 0) begin : g_head
      assign nbr_key = in_ch.new_key;
      assign nbr_tag = in_ch.new_tag;
    end else begin : g_body
      assign nbr_key = cell_key[i-1];
      assign nbr_tag = cell_tag[i-1];
    end

    assign cell_ctrl[i].ins      = in_fire && op_ins;
    assign cell_ctrl[i].desc     = desc_r;
    assign cell_ctrl[i].active   = (i < int'(count_r));
    assign cell_ctrl[i].prev_hit = any_hit[i];
    assign cell_ctrl[i].append   = append_ok && (int'(count_r) == i);

    tnsi_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .TAG_WIDTH (TAG_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[i]),
      .new_key (in_ch.new_key),
      .new_tag (in_ch.new_tag),
      .nbr_key (nbr_key),
      .nbr_tag (nbr_tag),
      .hit     (hit[i]),
      .key_r   (cell_key[i]),
      .tag_r   (cell_tag[i])
    );
  end

  // next count for the current request
  always_comb begin
    count_nxt = count_r;
    if (op_clr) begin
      count_nxt = '0;
    end else if (op_ins && (append_ok || (beaten && !full))) begin
      count_nxt = count_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_fire) begin
      count_r <= count_nxt;
    end
  end

  // insert outcome
  assign res_accepted = op_ins && (beaten || !full);
  assign res_evicted  = op_ins && beaten && full;

  // pick the last held entry and the read entry
  always_comb begin
    res_ev_key = '0;
    res_ev_tag = '0;
    res_rd_key = '0;
    res_rd_tag = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (res_evicted && (int'(count_r) == i + 1)) begin
        res_ev_key = cell_key[i];
        res_ev_tag = cell_tag[i];
      end
      if (res_rd_valid && (int'(in_ch.read_index) == i)) begin
        res_rd_key = cell_key[i];
        res_rd_tag = cell_tag[i];
      end
    end
  end

  assign res_rd_valid = op_rd && (int'(in_ch.read_index) < int'(count_r));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      accepted_r <= res_accepted;
      evicted_r  <= res_evicted;
      ev_key_r   <= res_ev_key;
      ev_tag_r   <= res_ev_tag;
      occ_r      <= count_nxt;
      rd_key_r   <= res_rd_key;
      rd_tag_r   <= res_rd_tag;
      rd_valid_r <= res_rd_valid;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = accepted_r;
  assign out_ch.evicted     = evicted_r;
  assign out_ch.evicted_key = ev_key_r;
  assign out_ch.evicted_tag = ev_tag_r;
  assign out_ch.occupancy   = occ_r;
  assign out_ch.read_key    = rd_key_r;
  assign out_ch.read_tag    = rd_tag_r;
  assign out_ch.read_valid  = rd_valid_r;

  // checks
  `TNSI_ASSERT_NOW(a_count_bound, 1'b1, int'(count_r) <= MAX_ENTRIES)
  `TNSI_ASSERT_NOW(a_evict_accepts, out_valid_r && evicted_r, accepted_r)
  `TNSI_ASSERT_NEXT(a_clear_empties, in_fire && op_clr, count_r == '0)
  `TNSI_ASSERT_NEXT(a_result_follows, in_fire, out_valid_r && (occ_r == count_r))

endmodule

@@ rtl/tnsi_cell.sv @@
// one cell of the sorted list: holds an entry, compares it, shifts it on
// depends on tnsi_pkg
module tnsi_cell
  import tnsi_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [TAG_WIDTH-1:0] new_tag,
  input  logic [KEY_WIDTH-1:0] nbr_key,
  input  logic [TAG_WIDTH-1:0] nbr_tag,
  output logic                 hit,
  output logic [KEY_WIDTH-1:0] key_r,
  output logic [TAG_WIDTH-1:0] tag_r
);

  logic [KEY_WIDTH-1:0] key_nxt;
  logic [TAG_WIDTH-1:0] tag_nxt;
  logic                 beats;

  // new key strictly beats the held one in the current order
  assign beats = ctrl.desc ? (new_key > key_r) : (new_key < key_r);
  assign hit   = ctrl.active && beats;

  // shift from neighbor, take the new entry, or hold
  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctrl.ins) begin
      if (ctrl.prev_hit) begin
        key_nxt = nbr_key;
        tag_nxt = nbr_tag;
      end else if (hit || ctrl.append) begin
        key_nxt = new_key;
        tag_nxt = new_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

endmodule
